// ===== src/gfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpa_pkg
// Types and constants shared by the free-list page allocator.
// ----------------------------------------------------------------------------
package gfpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int PAGE_W    = 10;
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(MAX_PAGES - 1);

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef struct packed {
    action_e           action;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    status_e           status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GROW,
    S_READ,
    S_DONE
  } state_e;

  // link table port
  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [PAGE_W-1:0] wdata;
    logic              re;
    logic [PAGE_W-1:0] raddr;
  } ram_req_t;

  // shared add / compare unit
  typedef struct packed {
    logic [PAGE_W-1:0] a;
    logic [PAGE_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [PAGE_W:0]   sum;
    logic [PAGE_W-1:0] sat;
    logic              gt;
  } alu_rsp_t;

endpackage

// ===== src/gfpa_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpa_alu
// Shared adder and comparator: a+b, a+b clamped to the last page, a>b.
// ----------------------------------------------------------------------------
module gfpa_alu (
  input  gfpa_pkg::alu_req_t alu_req_i,
  output gfpa_pkg::alu_rsp_t alu_rsp_o
);
  import gfpa_pkg::*;

  logic [PAGE_W:0] sum;

  assign sum = {1'b0, alu_req_i.a} + {1'b0, alu_req_i.b};

  always_comb begin
    alu_rsp_o.sum = sum;
    alu_rsp_o.sat = (sum > {1'b0, LAST_PAGE}) ? LAST_PAGE : sum[PAGE_W-1:0];
    alu_rsp_o.gt  = alu_req_i.a > alu_req_i.b;
  end

endmodule

// ===== src/gfpa_link_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpa_link_ram
// Next-link table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gfpa_link_ram (
  input  logic                            clk_i,
  input  gfpa_pkg::ram_req_t              ram_req_i,
  output logic [gfpa_pkg::PAGE_W-1:0]     rdata_o
);
  import gfpa_pkg::*;

  logic [PAGE_W-1:0] mem [MAX_PAGES];
  logic [PAGE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem[ram_req_i.waddr] <= ram_req_i.wdata;
    end
    if (ram_req_i.re) begin
      rdata_q <= mem[ram_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gfpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpa_ctrl
// Sequencer: list head, page count, growth walk and response register.
// ----------------------------------------------------------------------------
module gfpa_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  gfpa_pkg::req_t                  req_i,
  output logic                            busy_o,
  output logic                            done_o,
  output gfpa_pkg::rsp_t                  rsp_o,
  output gfpa_pkg::ram_req_t              ram_req_o,
  input  logic [gfpa_pkg::PAGE_W-1:0]     ram_rdata_i,
  output gfpa_pkg::alu_req_t              alu_req_o,
  input  gfpa_pkg::alu_rsp_t              alu_rsp_i
);
  import gfpa_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  rsp_t              rsp_q, rsp_d;
  logic [PAGE_W-1:0] head_q, head_d;
  logic [PAGE_W-1:0] used_q, used_d;
  logic [PAGE_W-1:0] cur_q, cur_d;
  logic [PAGE_W-1:0] link_q, link_d;
  logic [PAGE_W-1:0] end_q, end_d;

  logic              accept;
  logic              is_free;
  logic              head_empty;
  logic              store_full;
  logic              bad_page;
  logic              grow_last;

  assign accept     = start_i && (state_q == S_IDLE);
  assign is_free    = (req_q.action == ACT_FREE);
  assign head_empty = (head_q == '0);
  assign store_full = (used_q == LAST_PAGE);
  assign bad_page   = (req_q.page_number == '0) || alu_rsp_i.gt;
  assign grow_last  = (cur_q == end_q);

  // operand select for the shared unit
  always_comb begin
    alu_req_o = '{a: used_q, b: used_q};
    case (state_q)
      S_EXEC: begin
        if (is_free) begin
          alu_req_o = '{a: req_q.page_number, b: used_q};
        end else begin
          // growth size is max(1, used)
          alu_req_o = '{a: used_q, b: (used_q == '0) ? PAGE_W'(1) : used_q};
        end
      end
      S_GROW:  alu_req_o = '{a: cur_q, b: PAGE_W'(1)};
      default: alu_req_o = '{a: used_q, b: used_q};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (is_free) begin
          state_d = S_DONE;
        end else if (!head_empty) begin
          state_d = S_READ;
        end else if (store_full) begin
          state_d = S_DONE;
        end else begin
          state_d = S_GROW;
        end
      end
      S_GROW: begin
        if (grow_last) state_d = S_EXEC;
      end
      S_READ:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d     = req_q;
    rsp_d     = rsp_q;
    head_d    = head_q;
    used_d    = used_q;
    cur_d     = cur_q;
    link_d    = link_q;
    end_d     = end_q;
    ram_req_o = '{we: 1'b0, waddr: cur_q, wdata: link_q, re: 1'b0, raddr: head_q};
    case (state_q)
      S_IDLE: begin
        if (accept) req_d = req_i;
      end
      S_EXEC: begin
        if (is_free) begin
          if (bad_page) begin
            rsp_d = '{result_page: '0, status: ST_INVALID};
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = req_q.page_number;
            ram_req_o.wdata = head_q;
            head_d          = req_q.page_number;
            rsp_d           = '{result_page: '0, status: ST_OK};
          end
        end else if (!head_empty) begin
          ram_req_o.re = 1'b1;
        end else if (store_full) begin
          rsp_d = '{result_page: '0, status: ST_NO_SPACE};
        end else begin
          // new pages used+1 .. min(used+want, last page)
          cur_d  = used_q + PAGE_W'(1);
          link_d = head_q;
          end_d  = alu_rsp_i.sat;
        end
      end
      S_GROW: begin
        ram_req_o.we = 1'b1;
        link_d       = cur_q;
        cur_d        = alu_rsp_i.sum[PAGE_W-1:0];
        if (grow_last) begin
          head_d = cur_q;
          used_d = cur_q;
        end
      end
      S_READ: begin
        rsp_d  = '{result_page: head_q, status: ST_OK};
        head_d = ram_rdata_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    cur_q  <= cur_d;
    link_q <= link_d;
    end_q  <= end_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = rsp_q;

endmodule

// ===== src/growable_free_list_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// growable_free_list_page_allocator
// LIFO free-list page allocator that doubles its page store, up to the last page, when empty.
// ----------------------------------------------------------------------------
// Usage:
//   Command in: drive req_i and raise start_i; the beat is taken on a clock
//   edge where start_i is high and busy_o is low. busy_o stays high until
//   the response has been shown.
//   Response out: done_o is high for one cycle with rsp_o valid; the
//   receiver must take it then, it cannot be held off.
// Command paths, each ending with done_o:
//   free (or rejected free)
//   allocate from a non-empty list
//   allocate with store full
//   allocate with growth, n = pages added,
//     n = min(max(1, used), MAX_PAGES-1-used)
//   The growth walk writes one link per cycle through the single write port
//   of the link table. The next command is taken in the cycle after done_o.
// Reset: the list is empty and no page is in use; the link table is not
//   cleared, only entries that were linked are ever read.
// ----------------------------------------------------------------------------
module growable_free_list_page_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  gfpa_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output gfpa_pkg::rsp_t rsp_o
);
  import gfpa_pkg::*;

  ram_req_t          ram_req;
  logic [PAGE_W-1:0] ram_rdata;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  gfpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp)
  );

  gfpa_link_ram u_link_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (ram_rdata)
  );

  gfpa_alu u_alu (
    .alu_req_i (alu_req),
    .alu_rsp_o (alu_rsp)
  );

endmodule

// ===== src/gfpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfpa_checker
// Port-level checks of the allocator's command / response sequencing.
// ----------------------------------------------------------------------------
module gfpa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input gfpa_pkg::req_t req_i,
  input logic           busy_o,
  input logic           done_o,
  input gfpa_pkg::rsp_t rsp_o
);
  import gfpa_pkg::*;

  // a taken command holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after command beat");

  // a response is only shown while the command is still outstanding
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done_o without outstanding command");

  // one response beat per command, then the block frees up
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o)
    else $error("response not a single beat");

  // failed requests never hand out a page
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != ST_OK) |-> (rsp_o.result_page == '0))
    else $error("failed request returned a page");

  // a waiting command beat holds steady until taken
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && busy_o |=> start_i && $stable(req_i))
    else $error("command beat changed while waiting");

endmodule

bind growable_free_list_page_allocator gfpa_checker u_gfpa_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
